FILE: rtl/aes_pkg.sv
// Shared types, constants and round functions of the AES block cipher.
package aes_pkg;

  localparam int CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CFG_KEY_LENGTH = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_KEY_WORD0  = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_KEY_WORD3  = 3'd4;

  localparam logic [1:0] KL_128 = 2'd0;
  localparam logic [1:0] KL_192 = 2'd1;
  localparam logic [1:0] KL_256 = 2'd2;

  localparam logic [7:0] GF_POLY = 8'h1b;

  typedef logic [3:0][63:0] key_t;
  typedef logic [127:0] blk_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  function automatic logic [7:0] xtime(logic [7:0] a);
    return a[7] ? ({a[6:0], 1'b0} ^ GF_POLY) : {a[6:0], 1'b0};
  endfunction

  function automatic blk_t sub_bytes(blk_t s, logic inv);
    blk_t t;
    for (int b = 0; b < 16; b++) begin
      t[127-8*b -: 8] = inv ? INV_SBOX[s[127-8*b -: 8]] : SBOX[s[127-8*b -: 8]];
    end
    return t;
  endfunction

  // Byte c*4+r is row r of column c; row r rotates left by r positions.
  function automatic blk_t shift_rows(blk_t s, logic inv);
    blk_t t;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        if (inv) begin
          t[127-8*((((c+r)%4)*4)+r) -: 8] = s[127-8*(c*4+r) -: 8];
        end else begin
          t[127-8*(c*4+r) -: 8] = s[127-8*((((c+r)%4)*4)+r) -: 8];
        end
      end
    end
    return t;
  endfunction

  function automatic logic [31:0] mix_col_fwd(logic [31:0] col);
    logic [7:0] c0, c1, c2, c3;
    c0 = col[31:24];
    c1 = col[23:16];
    c2 = col[15:8];
    c3 = col[7:0];
    return {xtime(c0) ^ xtime(c1) ^ c1 ^ c2 ^ c3,
            c0 ^ xtime(c1) ^ xtime(c2) ^ c2 ^ c3,
            c0 ^ c1 ^ xtime(c2) ^ xtime(c3) ^ c3,
            xtime(c0) ^ c0 ^ c1 ^ c2 ^ xtime(c3)};
  endfunction

  function automatic logic [31:0] mix_col_inv(logic [31:0] col);
    logic [7:0] a [4];
    logic [7:0] m9 [4];
    logic [7:0] m11 [4];
    logic [7:0] m13 [4];
    logic [7:0] m14 [4];
    logic [7:0] x2, x4, x8;
    for (int k = 0; k < 4; k++) begin
      a[k] = col[31-8*k -: 8];
      x2 = xtime(a[k]);
      x4 = xtime(x2);
      x8 = xtime(x4);
      m9[k]  = x8 ^ a[k];
      m11[k] = x8 ^ x2 ^ a[k];
      m13[k] = x8 ^ x4 ^ a[k];
      m14[k] = x8 ^ x4 ^ x2;
    end
    return {m14[0] ^ m11[1] ^ m13[2] ^ m9[3],
            m9[0] ^ m14[1] ^ m11[2] ^ m13[3],
            m13[0] ^ m9[1] ^ m14[2] ^ m11[3],
            m11[0] ^ m13[1] ^ m9[2] ^ m14[3]};
  endfunction

  function automatic blk_t mix_columns(blk_t s, logic inv);
    blk_t t;
    for (int c = 0; c < 4; c++) begin
      t[127-32*c -: 32] = inv ? mix_col_inv(s[127-32*c -: 32]) : mix_col_fwd(s[127-32*c -: 32]);
    end
    return t;
  endfunction

endpackage

FILE: rtl/aes_key_expand.sv
// Key schedule sequencer: produces one 32-bit round key word per cycle while busy.
module aes_key_expand #(
  parameter int ROUND_KEY_SLOTS = 15,
  parameter int NRW = $clog2(ROUND_KEY_SLOTS),
  parameter int IW  = $clog2(4 * ROUND_KEY_SLOTS)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [1:0]        key_length_i,
  input  aes_pkg::key_t     key_i,
  input  logic [NRW-1:0]    nr_i,
  output logic              busy_o,
  output logic              we_o,
  output logic [IW-1:0]     idx_o,
  output logic [31:0]       word_o
);
  import aes_pkg::*;

  logic          busy_q, busy_d;
  logic [IW-1:0] idx_q, idx_d;
  logic [2:0]    pos_q, pos_d;
  logic [7:0]    rcon_q, rcon_d;
  logic [31:0]   win_q [8];
  logic [3:0]    nk;
  logic [IW-1:0] last;
  logic [31:0]   t, w;
  logic [63:0]   kw;

  assign nk   = (key_length_i == KL_128) ? 4'd4 : (key_length_i == KL_192) ? 4'd6 : 4'd8;
  assign last = IW'({nr_i, 2'b11});
  assign kw   = key_i[idx_q[2:1]];

  always_comb begin
    t      = win_q[0];
    rcon_d = rcon_q;
    if (idx_q < IW'(nk)) begin
      w = idx_q[0] ? kw[31:0] : kw[63:32];
    end else begin
      if (pos_q == 3'd0) begin
        t = {SBOX[win_q[0][23:16]] ^ rcon_q, SBOX[win_q[0][15:8]],
             SBOX[win_q[0][7:0]], SBOX[win_q[0][31:24]]};
        rcon_d = xtime(rcon_q);
      end else if (nk == 4'd8 && pos_q == 3'd4) begin
        t = {SBOX[win_q[0][31:24]], SBOX[win_q[0][23:16]],
             SBOX[win_q[0][15:8]], SBOX[win_q[0][7:0]]};
      end
      w = win_q[3'(nk - 4'd1)] ^ t;
    end
    busy_d = busy_q && (idx_q != last);
    idx_d  = idx_q + IW'(1);
    pos_d  = (pos_q == 3'(nk - 4'd1)) ? 3'd0 : pos_q + 3'd1;
    if (start_i) begin
      busy_d = 1'b1;
      idx_d  = '0;
      pos_d  = '0;
      rcon_d = 8'h01;
    end else if (!busy_q) begin
      idx_d  = idx_q;
      pos_d  = pos_q;
      rcon_d = rcon_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
      pos_q  <= '0;
      rcon_q <= 8'h01;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
      pos_q  <= pos_d;
      rcon_q <= rcon_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q && !start_i) begin
      win_q[0] <= w;
      for (int k = 1; k < 8; k++) begin
        win_q[k] <= win_q[k-1];
      end
    end
  end

  assign busy_o = busy_q;
  assign we_o   = busy_q && !start_i;
  assign idx_o  = idx_q;
  assign word_o = w;

endmodule

FILE: rtl/aes_round.sv
// One pipeline stage of the cipher: the initial key addition, or a full, final or skipped round in either direction.
module aes_round #(
  parameter int STAGE = 0,
  parameter int NRW = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  logic           func_i,
  input  aes_pkg::blk_t  state_i,
  input  logic [NRW-1:0] nr_i,
  input  aes_pkg::blk_t  key_i,
  output logic           valid_o,
  input  logic           ready_i,
  output logic           func_o,
  output aes_pkg::blk_t  state_o
);
  import aes_pkg::*;

  logic valid_q;
  logic func_q;
  blk_t state_q, state_d;

  if (STAGE == 0) begin : g_first
    assign state_d = state_i ^ key_i;
  end else begin : g_round
    logic [NRW-1:0] here;
    blk_t enc_sr, dec_d;
    assign here   = NRW'(STAGE);
    assign enc_sr = shift_rows(sub_bytes(state_i, 1'b0), 1'b0);
    assign dec_d  = sub_bytes(shift_rows(state_i, 1'b1), 1'b1) ^ key_i;
    always_comb begin
      if (here > nr_i) begin
        state_d = state_i;
      end else if (!func_i) begin
        state_d = ((here == nr_i) ? enc_sr : mix_columns(enc_sr, 1'b0)) ^ key_i;
      end else begin
        state_d = (here == nr_i) ? dec_d : mix_columns(dec_d, 1'b1);
      end
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      state_q <= state_d;
      func_q  <= func_i;
    end
  end

  assign valid_o = valid_q;
  assign func_o  = func_q;
  assign state_o = state_q;

endmodule

FILE: rtl/aes_block_cipher.sv
// Top level of the AES-128/192/256 ECB block cipher with an unrolled round pipeline.
//
// Usage: the key is loaded through the write port (cfg_we_i, cfg_index_i, cfg_wdata_i):
// index 0 is the key length, indexes 1 to 4 are the 64-bit key words, and other indexes
// are ignored. Each write to indexes 0 to 4 restarts the key schedule, which writes the
// 4*(rounds+1) round key words (44, 52 or 60), one per cycle; in_ready_o is low meanwhile.
// Blocks enter on the input channel (in_valid_i/in_ready_o) with func_i selecting encrypt
// or decrypt, and leave on the output channel (out_valid_o/out_ready_i) in order.
// Throughput is one transaction per cycle while out_ready_i is high and no key schedule
// runs. Each block passes a register for the initial key addition and one per round stage;
// shorter keys pass unused round stages unchanged, so every block goes through them all.
// Each stage has its own valid bit and takes new data when it is empty or its successor
// moves, so a stalled receiver fills the bubbles before the input side stops.
// Reset clears the valid bits, the key registers and the schedule sequencer; the round
// key store holds no defined value until a key is written.
module aes_block_cipher #(
  parameter int ROUND_KEY_SLOTS = 15
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [aes_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [63:0]                 cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        func_i,
  input  logic [63:0]                 block_hi_i,
  input  logic [63:0]                 block_lo_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [63:0]                 result_hi_o,
  output logic [63:0]                 result_lo_o
);
  import aes_pkg::*;

  localparam int NRMAX = ROUND_KEY_SLOTS - 1;
  localparam int NRW   = $clog2(ROUND_KEY_SLOTS);
  localparam int IW    = $clog2(4 * ROUND_KEY_SLOTS);
  localparam int SW    = $clog2(ROUND_KEY_SLOTS);

  logic [1:0]     key_length_q;
  key_t           key_q;
  logic [NRW-1:0] nr;
  logic [3:0]     nr_full;
  logic           cfg_hit;
  logic           busy, rk_we;
  logic [IW-1:0]  rk_idx;
  logic [31:0]    rk_word;
  blk_t           rk_q [ROUND_KEY_SLOTS];

  logic           vld [NRMAX+2];
  logic           rdy [NRMAX+2];
  logic           fn  [NRMAX+2];
  blk_t           st  [NRMAX+2];

  // Key length three runs as a 256-bit key; the round count is capped by the store depth.
  assign nr_full = (key_length_q == KL_128) ? 4'd10 : (key_length_q == KL_192) ? 4'd12 : 4'd14;
  assign nr      = (32'(nr_full) > NRMAX) ? NRW'(NRMAX) : NRW'(nr_full);
  assign cfg_hit = cfg_we_i && (cfg_index_i <= CFG_KEY_WORD3);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_length_q <= KL_128;
      key_q        <= '0;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_KEY_LENGTH) begin
        key_length_q <= cfg_wdata_i[1:0];
      end else if (cfg_index_i <= CFG_KEY_WORD3) begin
        key_q[2'(cfg_index_i - CFG_KEY_WORD0)] <= cfg_wdata_i;
      end
    end
  end

  aes_key_expand #(
    .ROUND_KEY_SLOTS(ROUND_KEY_SLOTS)
  ) u_key_expand (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (cfg_hit),
    .key_length_i(key_length_q),
    .key_i       (key_q),
    .nr_i        (nr),
    .busy_o      (busy),
    .we_o        (rk_we),
    .idx_o       (rk_idx),
    .word_o      (rk_word)
  );

  // Round key store: word 0 of a round key is its most significant word.
  always_ff @(posedge clk_i) begin
    if (rk_we) begin
      rk_q[rk_idx[IW-1:2]][(3 - rk_idx[1:0]) * 32 +: 32] <= rk_word;
    end
  end

  assign vld[0]     = in_valid_i && !busy;
  assign fn[0]      = func_i;
  assign st[0]      = {block_hi_i, block_lo_i};
  assign in_ready_o = rdy[0] && !busy;

  for (genvar j = 0; j <= NRMAX; j++) begin : g_stage
    logic [NRW-1:0] dec_slot;
    blk_t           key;
    // Decryption walks the round keys from the last one down.
    assign dec_slot = (NRW'(j) <= nr) ? nr - NRW'(j) : '0;
    assign key      = fn[j] ? rk_q[SW'(dec_slot)] : rk_q[j];

    aes_round #(
      .STAGE(j),
      .NRW  (NRW)
    ) u_round (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(vld[j]),
      .ready_o(rdy[j]),
      .func_i (fn[j]),
      .state_i(st[j]),
      .nr_i   (nr),
      .key_i  (key),
      .valid_o(vld[j+1]),
      .ready_i(rdy[j+1]),
      .func_o (fn[j+1]),
      .state_o(st[j+1])
    );
  end

  assign rdy[NRMAX+1] = out_ready_i;
  assign out_valid_o  = vld[NRMAX+1];
  assign result_hi_o  = st[NRMAX+1][127:64];
  assign result_lo_o  = st[NRMAX+1][63:0];

`ifndef NO_ASSERTIONS
  a_busy_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !in_ready_o)
    else $error("input accepted while the key schedule runs");
  a_cfg_starts_schedule: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_hit |=> busy)
    else $error("key write did not start the key schedule");
  a_accept_enters_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> vld[1])
    else $error("accepted block missing from the first stage");
`endif

endmodule
